// ----- sv/segment_cylinder_collision_check_defines.svh -----
// Assertion macros shared by the segment-cylinder collision checker.
`ifndef SEGMENT_CYLINDER_COLLISION_CHECK_DEFINES_SVH
`define SEGMENT_CYLINDER_COLLISION_CHECK_DEFINES_SVH

// Same-cycle implication, sampled on clk, masked during reset
`define SCC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, masked during reset
`define SCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/scc_pkg.sv -----
// Shared widths, register map and transfer types for the collision checker.
package scc_pkg;

  // coordinate width, all other widths follow from it
  localparam int CW    = 16;
  localparam int DW    = CW + 1;       // coordinate differences
  localparam int PW    = 2 * DW;       // products of differences
  localparam int DOTW  = PW + 2;       // dot product of a and b
  localparam int CRW   = PW + 1;       // cross product components
  localparam int CAW   = PW;           // magnitude of a cross component
  localparam int HW    = CAW / 2;      // half of a magnitude, for split squaring
  localparam int RW    = CW - 1;       // radius
  localparam int RSQW  = 2 * RW;       // radius squared
  localparam int DSQW  = 2 * CW;       // one squared segment component
  localparam int DDW   = DSQW + 2;     // squared segment length
  localparam int RHSW  = RSQW + DDW;   // r^2 * |d|^2
  localparam int CSQW  = 2 * CAW;      // one squared cross component
  localparam int LHSW  = CSQW + 2;     // |b x d|^2

  // register port
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 3;
  localparam int ADDR_W    = REG_IDX_W + 2;

  localparam logic [REG_IDX_W-1:0] REG_START_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_START_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_START_Z = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_GOAL_X  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_GOAL_Y  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_GOAL_Z  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_RADIUS  = 3'd6;

  // number of datapath stages ahead of the output register
  localparam int NSTAGE = 5;

  typedef struct packed {
    logic signed [CW-1:0] obstacle_x;
    logic signed [CW-1:0] obstacle_y;
    logic signed [CW-1:0] obstacle_z;
    logic                 last_point;
  } point_t;

  typedef struct packed {
    logic point_hit;
    logic clear_so_far;
    logic end_of_cloud;
  } result_t;

  typedef struct packed {
    logic [CW-1:0] start_x;
    logic [CW-1:0] start_y;
    logic [CW-1:0] start_z;
    logic [CW-1:0] goal_x;
    logic [CW-1:0] goal_y;
    logic [CW-1:0] goal_z;
    logic [RW-1:0] radius;
  } seg_cfg_t;

  // load enables, one per datapath stage
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } pipe_en_t;

  // hand-over from the front stages to the squaring stages
  typedef struct packed {
    logic                     between;
    logic [2:0][CAW-1:0]      cabs;
    logic [DDW-1:0]           dd;
    logic [RSQW-1:0]          rsq;
  } front_out_t;

endpackage

// ----- sv/scc_front.sv -----
// Stages 1 to 3: differences, products, end-face test and cross product magnitudes.
module scc_front (
  input  logic              clk,
  input  scc_pkg::pipe_en_t en,
  input  scc_pkg::seg_cfg_t cfg,
  input  scc_pkg::point_t   pt,
  output scc_pkg::front_out_t res
);
  import scc_pkg::*;

  logic signed [CW-1:0] s_c [3];
  logic signed [CW-1:0] g_c [3];
  logic signed [CW-1:0] p_c [3];

  assign s_c[0] = $signed(cfg.start_x);
  assign s_c[1] = $signed(cfg.start_y);
  assign s_c[2] = $signed(cfg.start_z);
  assign g_c[0] = $signed(cfg.goal_x);
  assign g_c[1] = $signed(cfg.goal_y);
  assign g_c[2] = $signed(cfg.goal_z);
  assign p_c[0] = pt.obstacle_x;
  assign p_c[1] = pt.obstacle_y;
  assign p_c[2] = pt.obstacle_z;

  // stage 1: a = start - p, b = goal - p, d = goal - start
  logic signed [DW-1:0] a1 [3];
  logic signed [DW-1:0] b1 [3];
  logic signed [DW-1:0] d1 [3];
  logic [RW-1:0]        r1;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      for (int i = 0; i < 3; i++) begin
        a1[i] <= DW'(s_c[i]) - DW'(p_c[i]);
        b1[i] <= DW'(g_c[i]) - DW'(p_c[i]);
        d1[i] <= DW'(g_c[i]) - DW'(s_c[i]);
      end
      r1 <= cfg.radius;
    end
  end

  // stage 2: all pairwise products
  logic signed [PW-1:0] ab2 [3];
  logic signed [PW-1:0] xa2 [3];
  logic signed [PW-1:0] xb2 [3];
  logic [DSQW-1:0]      dsq2 [3];
  logic [RSQW-1:0]      rsq2;
  logic signed [PW-1:0] dprod [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dprod[i] = d1[i] * d1[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      for (int i = 0; i < 3; i++) begin
        ab2[i]  <= a1[i] * b1[i];
        dsq2[i] <= dprod[i][DSQW-1:0];
      end
      // b x d, each component as xa - xb
      xa2[0] <= b1[1] * d1[2];
      xb2[0] <= d1[1] * b1[2];
      xa2[1] <= d1[0] * b1[2];
      xb2[1] <= b1[0] * d1[2];
      xa2[2] <= b1[0] * d1[1];
      xb2[2] <= d1[0] * b1[1];
      rsq2   <= r1 * r1;
    end
  end

  // stage 3: dot product sign, cross components and their magnitudes
  logic signed [DOTW-1:0] dot;
  logic signed [CRW-1:0]  cr [3];
  logic [CRW-1:0]         cmag [3];
  logic [DDW-1:0]         dd_sum;

  always_comb begin
    dot    = DOTW'(ab2[0]) + DOTW'(ab2[1]) + DOTW'(ab2[2]);
    dd_sum = DDW'(dsq2[0]) + DDW'(dsq2[1]) + DDW'(dsq2[2]);
    for (int i = 0; i < 3; i++) begin
      cr[i]   = CRW'(xa2[i]) - CRW'(xb2[i]);
      cmag[i] = cr[i][CRW-1] ? -cr[i] : cr[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      // a.b <= 0: point lies between the end faces, faces included
      res.between <= dot[DOTW-1] || (dot == '0);
      for (int i = 0; i < 3; i++) begin
        res.cabs[i] <= cmag[i][CAW-1:0];
      end
      res.dd  <= dd_sum;
      res.rsq <= rsq2;
    end
  end

endmodule

// ----- sv/scc_square.sv -----
// Stages 4 and 5: split squaring of the cross product, r^2*|d|^2, and the distance compare.
module scc_square (
  input  logic                  clk,
  input  scc_pkg::pipe_en_t     en,
  input  scc_pkg::front_out_t   fr,
  output logic                  hit
);
  import scc_pkg::*;

  logic [HW-1:0] hi [3];
  logic [HW-1:0] lo [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hi[i] = fr.cabs[i][CAW-1:HW];
      lo[i] = fr.cabs[i][HW-1:0];
    end
  end

  // stage 4: partial products of each magnitude squared, and the radius side
  logic [2*HW-1:0] hh4 [3];
  logic [2*HW-1:0] hl4 [3];
  logic [2*HW-1:0] ll4 [3];
  logic [RHSW-1:0] rhs4;
  logic            between4;

  always_ff @(posedge clk) begin
    if (en.s4) begin
      for (int i = 0; i < 3; i++) begin
        hh4[i] <= hi[i] * hi[i];
        hl4[i] <= hi[i] * lo[i];
        ll4[i] <= lo[i] * lo[i];
      end
      rhs4     <= fr.rsq * fr.dd;
      between4 <= fr.between;
    end
  end

  // stage 5: recombine, c^2 = hh<<2H + hl<<(H+1) + ll
  logic [CSQW-1:0] csq5 [3];
  logic [RHSW-1:0] rhs5;
  logic            between5;

  always_ff @(posedge clk) begin
    if (en.s5) begin
      for (int i = 0; i < 3; i++) begin
        csq5[i] <= (CSQW'(hh4[i]) << (2 * HW)) + (CSQW'(hl4[i]) << (HW + 1))
                   + CSQW'(ll4[i]);
      end
      rhs5     <= rhs4;
      between5 <= between4;
    end
  end

  // strict compare; a zero-length segment or zero radius never hits
  logic [LHSW-1:0] lhs;

  always_comb begin
    lhs = LHSW'(csq5[0]) + LHSW'(csq5[1]) + LHSW'(csq5[2]);
    hit = between5 && (lhs < LHSW'(rhs5));
  end

endmodule

// ----- sv/segment_cylinder_collision_check.sv -----
// Top level: register port, pipeline control, result register and per-cloud sticky flag.
//
// Obstacle points arrive on the point channel (point_valid/point_ready), one per
// transfer, and each yields exactly one result on the result channel
// (result_valid/result_ready), in order. A result carries point_hit, the sticky
// clear_so_far flag and end_of_cloud, an echo of last_point; on the result that
// ends a cloud clear_so_far is the verdict for the whole cloud, and the sticky
// flag then starts afresh for the next point.
// The segment start, goal and radius sit in APB registers at 4-byte steps; write
// them only while no point is in flight. pready is tied high.
// A transferred point is registered in stage 1, then in each stage up to stage 5, then in
// the output register; a stall can hold it in any stage. Throughput: one point per cycle
// while the receiver keeps up, set by the fully pipelined multiply and compare stages.
// Reset (rst, synchronous) empties the pipeline, drops result_valid, clears the
// sticky flag and sets every APB register to zero.
// When the receiver stalls, the pipeline keeps filling its empty stages; point_ready
// falls only once every stage holds a point and the result waits to be taken.
`include "segment_cylinder_collision_check_defines.svh"

module segment_cylinder_collision_check (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [scc_pkg::ADDR_W-1:0]    paddr,
  input  logic [scc_pkg::DATA_W-1:0]    pwdata,
  output logic [scc_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  input  logic                          point_valid,
  output logic                          point_ready,
  input  scc_pkg::point_t               point,
  output logic                          result_valid,
  input  logic                          result_ready,
  output scc_pkg::result_t              result
);
  import scc_pkg::*;

  // register file
  seg_cfg_t                cfg;
  logic [REG_IDX_W-1:0]    reg_idx;
  logic                    reg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_START_X: cfg.start_x <= pwdata[CW-1:0];
        REG_START_Y: cfg.start_y <= pwdata[CW-1:0];
        REG_START_Z: cfg.start_z <= pwdata[CW-1:0];
        REG_GOAL_X:  cfg.goal_x  <= pwdata[CW-1:0];
        REG_GOAL_Y:  cfg.goal_y  <= pwdata[CW-1:0];
        REG_GOAL_Z:  cfg.goal_z  <= pwdata[CW-1:0];
        REG_RADIUS:  cfg.radius  <= pwdata[RW-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx)
      REG_START_X: prdata = DATA_W'(cfg.start_x);
      REG_START_Y: prdata = DATA_W'(cfg.start_y);
      REG_START_Z: prdata = DATA_W'(cfg.start_z);
      REG_GOAL_X:  prdata = DATA_W'(cfg.goal_x);
      REG_GOAL_Y:  prdata = DATA_W'(cfg.goal_y);
      REG_GOAL_Z:  prdata = DATA_W'(cfg.goal_z);
      REG_RADIUS:  prdata = DATA_W'(cfg.radius);
      default:     prdata = '0;
    endcase
  end

  // stage enables: a stage loads when empty or when the one after it moves on
  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] last_p;
  logic              out_free;
  pipe_en_t          en;

  assign out_free    = !result_valid || result_ready;
  assign en.s5       = !vld[4] || out_free;
  assign en.s4       = !vld[3] || en.s5;
  assign en.s3       = !vld[2] || en.s4;
  assign en.s2       = !vld[1] || en.s3;
  assign en.s1       = !vld[0] || en.s2;
  assign point_ready = en.s1;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en.s1) vld[0] <= point_valid;
      if (en.s2) vld[1] <= vld[0];
      if (en.s3) vld[2] <= vld[1];
      if (en.s4) vld[3] <= vld[2];
      if (en.s5) vld[4] <= vld[3];
    end
  end

  // end-of-cloud marks alongside
  always_ff @(posedge clk) begin
    if (en.s1) last_p[0] <= point.last_point;
    if (en.s2) last_p[1] <= last_p[0];
    if (en.s3) last_p[2] <= last_p[1];
    if (en.s4) last_p[3] <= last_p[2];
    if (en.s5) last_p[4] <= last_p[3];
  end

  // datapath
  front_out_t fr;
  logic       hit;

  scc_front u_front (
    .clk (clk),
    .en  (en),
    .cfg (cfg),
    .pt  (point),
    .res (fr)
  );

  scc_square u_square (
    .clk (clk),
    .en  (en),
    .fr  (fr),
    .hit (hit)
  );

  // result register and sticky hit flag, updated as a point leaves stage 5
  logic hit_seen;
  logic any_hit;

  assign any_hit = hit_seen || hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      hit_seen     <= 1'b0;
    end else if (out_free) begin
      result_valid <= vld[4];
      if (vld[4]) begin
        hit_seen <= last_p[4] ? 1'b0 : any_hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      result.point_hit    <= hit;
      result.clear_so_far <= !any_hit;
      result.end_of_cloud <= last_p[4];
    end
  end

  // checks
  `SCC_ASSERT_NOW(a_stall_from_output, !point_ready, result_valid && !result_ready, "input stalled while output free")
  `SCC_ASSERT_NEXT(a_sticky_clears, out_free && vld[4] && last_p[4], !hit_seen, "sticky flag kept")
  `SCC_ASSERT_NOW(a_hit_not_clear, result_valid, !(result.point_hit && result.clear_so_far), "hit reported as clear")
  `SCC_ASSERT_NEXT(a_accept_fills, point_valid && point_ready, vld[0], "accepted point lost at stage 1")

endmodule

// ----- test/segment_cylinder_collision_check_tb.sv -----
// Self-checking testbench for the segment-cylinder collision checker.
module segment_cylinder_collision_check_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import scc_pkg::*;

  localparam int unsigned HOLD_CYCLES   = 80;    // long receiver hold-off
  localparam int unsigned IDLE_LIMIT    = 4000;  // watchdog: cycles with no transfer
  localparam int unsigned END_WAIT      = 20;    // settle time after the last result
  localparam int unsigned RAND_PHASES   = 8;
  localparam int unsigned PHASE_POINTS  = 105;
  localparam int unsigned PRESSURE_RUN  = 30;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef logic signed [127:0] wide_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_W-1:0]    paddr;
  logic [DATA_W-1:0]    pwdata;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;
  logic                 point_valid;
  logic                 point_ready;
  point_t               point;
  logic                 result_valid;
  logic                 result_ready;
  result_t              result;

  // Predicts each verdict and checks results in transfer order
  class collision_scoreboard;
    logic signed [CW-1:0] seg_start [3];
    logic signed [CW-1:0] seg_goal [3];
    logic [RW-1:0]        radius;
    bit                   hit_seen;
    result_t              expected_verdicts [$];
    int unsigned          results_seen;
    int unsigned          mismatches;
    int unsigned          hits_predicted;

    function new();
      foreach (seg_start[k]) begin
        seg_start[k] = '0;
        seg_goal[k]  = '0;
      end
      radius         = '0;
      hit_seen       = 1'b0;
      results_seen   = 0;
      mismatches     = 0;
      hits_predicted = 0;
    endfunction

    // Only the low bits of each register's width count
    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_START_X: seg_start[0] = value[CW-1:0];
        REG_START_Y: seg_start[1] = value[CW-1:0];
        REG_START_Z: seg_start[2] = value[CW-1:0];
        REG_GOAL_X:  seg_goal[0]  = value[CW-1:0];
        REG_GOAL_Y:  seg_goal[1]  = value[CW-1:0];
        REG_GOAL_Z:  seg_goal[2]  = value[CW-1:0];
        REG_RADIUS:  radius       = value[RW-1:0];
        default: ;
      endcase
    endfunction

    // Between the end faces, and strictly closer than r to the axis
    function bit point_in_cylinder(point_t p);
      logic signed [CW-1:0] pc [3];
      wide_t a [3];
      wide_t b [3];
      wide_t d [3];
      wide_t cx, cy, cz, ab, lhs, rhs, r;
      pc[0] = p.obstacle_x;
      pc[1] = p.obstacle_y;
      pc[2] = p.obstacle_z;
      for (int k = 0; k < 3; k++) begin
        a[k] = wide_t'(seg_start[k]) - wide_t'(pc[k]);
        b[k] = wide_t'(seg_goal[k]) - wide_t'(pc[k]);
        d[k] = wide_t'(seg_goal[k]) - wide_t'(seg_start[k]);
      end
      ab  = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
      cx  = b[1] * d[2] - d[1] * b[2];
      cy  = d[0] * b[2] - b[0] * d[2];
      cz  = b[0] * d[1] - d[0] * b[1];
      lhs = cx * cx + cy * cy + cz * cz;
      r   = wide_t'(radius);
      rhs = r * r * (d[0] * d[0] + d[1] * d[1] + d[2] * d[2]);
      return (ab <= 0) && (lhs < rhs);
    endfunction

    function void note_point(point_t p);
      result_t want;
      bit hit, any;
      hit = point_in_cylinder(p);
      any = hit_seen || hit;
      want.point_hit    = hit;
      want.clear_so_far = !any;
      want.end_of_cloud = p.last_point;
      hit_seen = p.last_point ? 1'b0 : any;
      if (hit) hits_predicted++;
      expected_verdicts.insert(expected_verdicts.size(), want);
    endfunction

    function void check_result(result_t got);
      result_t want;
      results_seen++;
      if (expected_verdicts.size() == 0) begin
        if (mismatches < 10)
          $display("[%0t] unexpected result hit=%b clear=%b end=%b", $realtime,
                   got.point_hit, got.clear_so_far, got.end_of_cloud);
        mismatches++;
      end else begin
        want = expected_verdicts.pop_front();
        if (got.point_hit !== want.point_hit || got.clear_so_far !== want.clear_so_far ||
            got.end_of_cloud !== want.end_of_cloud) begin
          if (mismatches < 10)
            $display("[%0t] result %0d: expected hit=%b clear=%b end=%b, got hit=%b clear=%b end=%b",
                     $realtime, results_seen, want.point_hit, want.clear_so_far,
                     want.end_of_cloud, got.point_hit, got.clear_so_far, got.end_of_cloud);
          mismatches++;
        end
      end
    endfunction
  endclass

  collision_scoreboard sb = new();

  int unsigned burst_left    = 0;
  int unsigned hold_requests = 0;
  int unsigned points_sent   = 0;
  int unsigned clouds_sent   = 0;
  int unsigned settings_used = 0;
  int unsigned idle_count    = 0;

  segment_cylinder_collision_check dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .point_valid  (point_valid),
    .point_ready  (point_ready),
    .point        (point),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #6 clk = ~clk;

  // Transfer monitor: note accepted points, check accepted results
  always @(posedge clk) begin
    if (!rst) begin
      if (point_valid && point_ready) sb.note_point(point);
      if (result_valid && result_ready) sb.check_result(result);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((point_valid && point_ready) || (result_valid && result_ready) ||
        (psel && penable && pwrite && pready))
      idle_count <= 0;
    else
      idle_count <= idle_count + 1;
    if (idle_count == IDLE_LIMIT) begin
      $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, IDLE_LIMIT);
      $display("segment_cylinder_collision_check_tb: errors");
      $finish;
    end
  end

  // Result sink: stall pattern drawn at random from four modes; long hold-off on request
  initial begin : result_sink
    int unsigned cyc;
    int unsigned mode;
    cyc  = 0;
    mode = 0;
    result_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != 0) begin
        hold_requests = 0;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        cyc++;
        if (cyc % 40 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0: result_ready <= 1'b1;
          1: result_ready <= ($urandom_range(0, 3) != 0);
          2: result_ready <= ($urandom_range(0, 3) == 0);
          default: result_ready <= ((cyc % 7) < 3);
        endcase
      end
    end
  end

  // One point transfer; returns just after the accepting edge
  task automatic send_point(input point_t p);
    point_valid <= 1'b1;
    point       <= p;
    @(posedge clk);
    while (!point_ready) @(posedge clk);
    points_sent++;
    if (p.last_point) clouds_sent++;
  endtask

  // Bursts of random length with random gaps between them
  task automatic pace();
    int unsigned gap;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 10);
      point_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 8);
    end
  endtask

  // Stop offering points and wait for every verdict to come back
  task automatic drain();
    point_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_verdicts.size() != 0) @(posedge clk);
  endtask

  // APB write: setup, access, then idle; upper data bits are junk
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CW-1:0] value);
    logic [DATA_W-1:0] word;
    word = {16'($urandom_range(0, 65535)), value};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, word);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_segment(input logic [CW-1:0] sx, input logic [CW-1:0] sy,
                             input logic [CW-1:0] sz, input logic [CW-1:0] gx,
                             input logic [CW-1:0] gy, input logic [CW-1:0] gz,
                             input logic [CW-1:0] r);
    drain();
    write_reg(REG_START_X, sx);
    write_reg(REG_START_Y, sy);
    write_reg(REG_START_Z, sz);
    write_reg(REG_GOAL_X, gx);
    write_reg(REG_GOAL_Y, gy);
    write_reg(REG_GOAL_Z, gz);
    write_reg(REG_RADIUS, r);
    settings_used++;
  endtask

  // Mix of points near the current segment, end points, corners and noise
  function automatic point_t random_point();
    point_t p;
    int unsigned pick;
    int t, r, off, v;
    logic [CW-1:0] c [3];
    pick = $urandom_range(0, 9);
    t    = $urandom_range(0, 320);
    t    = t - 32;
    r    = int'(sb.radius);
    for (int k = 0; k < 3; k++) begin
      if (pick <= 5) begin
        off = $urandom_range(0, 2 * r + 64);
        off = off - (r + 32);
        v = int'(sb.seg_start[k]) + ((int'(sb.seg_goal[k]) - int'(sb.seg_start[k])) * t) / 256
            + off;
        c[k] = v[CW-1:0];
      end else if (pick <= 7) begin
        c[k] = 16'($urandom_range(0, 65535));
      end else if (pick == 8) begin
        c[k] = (t < 144) ? sb.seg_start[k] : sb.seg_goal[k];
      end else begin
        case ($urandom_range(0, 2))
          0: c[k] = 16'h8000;
          1: c[k] = 16'h7FFF;
          default: c[k] = 16'h0000;
        endcase
      end
    end
    // end-point picks must share one end across all axes
    if (pick == 8) begin
      for (int k = 0; k < 3; k++) c[k] = (t < 144) ? sb.seg_start[k] : sb.seg_goal[k];
    end
    p.obstacle_x = c[0];
    p.obstacle_y = c[1];
    p.obstacle_z = c[2];
    p.last_point = ($urandom_range(0, 7) == 0);
    return p;
  endfunction

  // Segment for one random phase: zero length, zero radius, extremes or general
  task automatic random_segment(input int unsigned phase);
    logic [CW-1:0] s [3];
    logic [CW-1:0] g [3];
    logic [CW-1:0] r;
    for (int k = 0; k < 3; k++) begin
      s[k] = 16'($urandom_range(0, 65535));
      g[k] = ($urandom_range(0, 1) == 0) ? (s[k] + 16'($urandom_range(0, 4095)) - 16'h0800)
                                         : 16'($urandom_range(0, 65535));
    end
    r = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 65535))
                                    : 16'($urandom_range(0, 4095));
    case (phase)
      2: set_segment(s[0], s[1], s[2], s[0], s[1], s[2], r);
      5: set_segment(s[0], s[1], s[2], g[0], g[1], g[2], 16'h0000);
      6: set_segment(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF);
      default: set_segment(s[0], s[1], s[2], g[0], g[1], g[2], r);
    endcase
  endtask

  // Main sequence
  initial begin : stimulus
    rst         <= 1'b1;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    point_valid <= 1'b0;
    point       <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers at reset: zero-length segment, zero radius
    send_point('{16'h0000, 16'h0000, 16'h0000, 1'b0});
    send_point('{16'h7FFF, 16'h8000, 16'h0001, 1'b1});

    // 10 m segment on x, 1 m radius; the unused register index is written too
    set_segment(16'h0000, 16'h0000, 16'h0000, 16'h0A00, 16'h0000, 16'h0000, 16'h0100);
    write_reg(REG_UNUSED, 16'hFFFF);
    send_point('{16'h0000, 16'h0000, 16'h0000, 1'b0});  // on the start face
    send_point('{16'h0A00, 16'h0000, 16'h0000, 1'b0});  // on the goal face
    send_point('{16'h0500, 16'h00FF, 16'h0000, 1'b0});  // just inside
    send_point('{16'h0500, 16'h0100, 16'h0000, 1'b1});  // exactly on the radius
    send_point('{16'hFFFF, 16'h0000, 16'h0000, 1'b0});  // behind the start
    send_point('{16'h0A01, 16'h0000, 16'h0000, 1'b0});  // past the goal
    send_point('{16'h8000, 16'h8000, 16'h8000, 1'b0});
    send_point('{16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1});  // cloud with no hit
    send_point('{16'h0300, 16'h0000, 16'h0080, 1'b0});  // hit, then the flag sticks
    send_point('{16'h0300, 16'h7FFF, 16'h0000, 1'b1});
    send_point('{16'h0300, 16'h7FFF, 16'h0000, 1'b1});  // fresh cloud of one

    // Full-range diagonal with the largest radius
    set_segment(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_point('{16'h0000, 16'h0000, 16'h0000, 1'b0});
    send_point('{16'h8000, 16'h8000, 16'h8000, 1'b0});
    send_point('{16'h7FFF, 16'h8000, 16'h0000, 1'b0});
    send_point('{16'h8000, 16'h7FFF, 16'h7FFF, 1'b1});

    // Zero radius, with bit 15 set as excess: nothing may hit
    drain();
    write_reg(REG_RADIUS, 16'h8000);
    send_point('{16'h0000, 16'h0000, 16'h0000, 1'b1});

    // Zero-length segment with a large radius
    set_segment(16'h1234, 16'hEDCC, 16'h0100, 16'h1234, 16'hEDCC, 16'h0100, 16'h7FFF);
    send_point('{16'h1234, 16'hEDCC, 16'h0100, 1'b0});
    send_point('{16'h1200, 16'hEDCC, 16'h0100, 1'b1});

    // Random phases; one of them holds the receiver off while points keep coming
    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      random_segment(ph);
      if (ph == 3) hold_requests = 1;
      for (int unsigned n = 0; n < PHASE_POINTS; n++) begin
        send_point(random_point());
        if (!(ph == 3 && n < PRESSURE_RUN)) pace();
      end
    end

    drain();
    repeat (END_WAIT) @(posedge clk);

    $display("covered %0d points in %0d clouds over %0d segment settings",
             points_sent, clouds_sent, settings_used);
    $display("%0d results checked, %0d predicted hits, %0d mismatches",
             sb.results_seen, sb.hits_predicted, sb.mismatches);
    if (sb.mismatches == 0)
      $display("segment_cylinder_collision_check_tb: clean");
    else
      $display("segment_cylinder_collision_check_tb: errors");
    $finish;
  end

endmodule
